FILE: sv/lifo_stack_with_sort_reverse_core_assert.svh
// ----------------------------------------------------------------------------
// lifo_stack_with_sort_reverse_core_assert.svh
// Assertion macros shared by the stack core.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SORT_REVERSE_CORE_ASSERT_SVH
`define LIFO_STACK_WITH_SORT_REVERSE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lssr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LSSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lssr: next-cycle check failed");

`endif

FILE: sv/lssr_pkg.sv
// ----------------------------------------------------------------------------
// lssr_pkg
// Sizes, action codes, micro-op codes and the microcode ROM of the stack core.
// ----------------------------------------------------------------------------
package lssr_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 8;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ACT_W  = 3;
	localparam int UPC_W  = 5;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [UPC_W-1:0]  upc_t;

	// Requested actions
	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH = 3'd0,
		ACT_POP  = 3'd1,
		ACT_PEEK = 3'd2,
		ACT_REV  = 3'd3,
		ACT_SORT = 3'd4
	} act_t;

	// Datapath operations, one per control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_PUSH,
		OP_POP_RD,
		OP_PEEK_RD,
		OP_EMIT_RD,
		OP_EMIT_OK,
		OP_EMIT_FAIL,
		OP_RV_INIT,
		OP_RV_TEST,
		OP_RV_LOAD,
		OP_WR_LO,
		OP_WR_HI,
		OP_SRT_INIT,
		OP_SRT_OUTER,
		OP_SRT_LOADV,
		OP_SRT_RDPREV
	} uop_t;

	// Step sequencing conditions
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_DISPATCH,
		C_RV_END,
		C_I_END,
		C_J_ZERO,
		C_NOT_LESS
	} cond_t;

	// Sort moves need two more ops; kept in a second group to fit four bits
	typedef enum logic [1:0] {
		WOP_NONE,
		WOP_SHIFT,
		WOP_PLACE
	} wop_t;

	typedef struct packed {
		uop_t  op;
		wop_t  wop;
		cond_t cond;
		upc_t  tgt;
		logic  emit;
	} cw_t;

	// Step addresses
	localparam upc_t UPC_IDLE     = 5'd0;
	localparam upc_t UPC_PUSH     = 5'd1;
	localparam upc_t UPC_POP      = 5'd2;
	localparam upc_t UPC_RD_EMIT  = 5'd3;
	localparam upc_t UPC_PEEK     = 5'd4;
	localparam upc_t UPC_BAD      = 5'd5;
	localparam upc_t UPC_RV_INIT  = 5'd6;
	localparam upc_t UPC_RV_TEST  = 5'd7;
	localparam upc_t UPC_RV_LOAD  = 5'd8;
	localparam upc_t UPC_RV_WLO   = 5'd9;
	localparam upc_t UPC_RV_WHI   = 5'd10;
	localparam upc_t UPC_DONE     = 5'd11;
	localparam upc_t UPC_S_INIT   = 5'd12;
	localparam upc_t UPC_S_OUTER  = 5'd13;
	localparam upc_t UPC_S_LOADV  = 5'd14;
	localparam upc_t UPC_S_RDPREV = 5'd15;
	localparam upc_t UPC_S_CMP    = 5'd16;
	localparam upc_t UPC_S_SHIFT  = 5'd17;
	localparam upc_t UPC_S_PLACE  = 5'd18;

	// Entry point of the program for each action
	function automatic upc_t entry_of(logic [ACT_W-1:0] a);
		upc_t e;
		unique case (a)
			ACT_PUSH: e = UPC_PUSH;
			ACT_POP:  e = UPC_POP;
			ACT_PEEK: e = UPC_PEEK;
			ACT_REV:  e = UPC_RV_INIT;
			ACT_SORT: e = UPC_S_INIT;
			default:  e = UPC_BAD;
		endcase
		return e;
	endfunction

	// Microcode ROM
	function automatic cw_t ucode(upc_t pc);
		cw_t w;
		unique case (pc)
			UPC_IDLE:     w = '{OP_NOP,        WOP_NONE,  C_DISPATCH, UPC_IDLE,     1'b0};
			UPC_PUSH:     w = '{OP_PUSH,       WOP_NONE,  C_ALWAYS,   UPC_IDLE,     1'b1};
			UPC_POP:      w = '{OP_POP_RD,     WOP_NONE,  C_NEXT,     UPC_IDLE,     1'b0};
			UPC_RD_EMIT:  w = '{OP_EMIT_RD,    WOP_NONE,  C_ALWAYS,   UPC_IDLE,     1'b1};
			UPC_PEEK:     w = '{OP_PEEK_RD,    WOP_NONE,  C_ALWAYS,   UPC_RD_EMIT,  1'b0};
			UPC_BAD:      w = '{OP_EMIT_FAIL,  WOP_NONE,  C_ALWAYS,   UPC_IDLE,     1'b1};
			UPC_RV_INIT:  w = '{OP_RV_INIT,    WOP_NONE,  C_NEXT,     UPC_IDLE,     1'b0};
			UPC_RV_TEST:  w = '{OP_RV_TEST,    WOP_NONE,  C_RV_END,   UPC_DONE,     1'b0};
			UPC_RV_LOAD:  w = '{OP_RV_LOAD,    WOP_NONE,  C_NEXT,     UPC_IDLE,     1'b0};
			UPC_RV_WLO:   w = '{OP_WR_LO,      WOP_NONE,  C_NEXT,     UPC_IDLE,     1'b0};
			UPC_RV_WHI:   w = '{OP_WR_HI,      WOP_NONE,  C_ALWAYS,   UPC_RV_TEST,  1'b0};
			UPC_DONE:     w = '{OP_EMIT_OK,    WOP_NONE,  C_ALWAYS,   UPC_IDLE,     1'b1};
			UPC_S_INIT:   w = '{OP_SRT_INIT,   WOP_NONE,  C_NEXT,     UPC_IDLE,     1'b0};
			UPC_S_OUTER:  w = '{OP_SRT_OUTER,  WOP_NONE,  C_I_END,    UPC_DONE,     1'b0};
			UPC_S_LOADV:  w = '{OP_SRT_LOADV,  WOP_NONE,  C_NEXT,     UPC_IDLE,     1'b0};
			UPC_S_RDPREV: w = '{OP_SRT_RDPREV, WOP_NONE,  C_J_ZERO,   UPC_S_PLACE,  1'b0};
			UPC_S_CMP:    w = '{OP_NOP,        WOP_NONE,  C_NOT_LESS, UPC_S_PLACE,  1'b0};
			UPC_S_SHIFT:  w = '{OP_NOP,        WOP_SHIFT, C_ALWAYS,   UPC_S_RDPREV, 1'b0};
			UPC_S_PLACE:  w = '{OP_NOP,        WOP_PLACE, C_ALWAYS,   UPC_S_OUTER,  1'b0};
			default:      w = '{OP_NOP,        WOP_NONE,  C_ALWAYS,   UPC_IDLE,     1'b0};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/lssr_req_if.sv
// ----------------------------------------------------------------------------
// lssr_req_if
// Request channel of the stack core: one action per beat.
// ----------------------------------------------------------------------------
interface lssr_req_if;
	import lssr_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACT_W-1:0]    action;
	logic [DATA_W-1:0]   push_value;

	modport source (output valid, action, push_value, input ready);
	modport sink   (input valid, action, push_value, output ready);
endinterface

FILE: sv/lssr_rsp_if.sv
// ----------------------------------------------------------------------------
// lssr_rsp_if
// Response channel of the stack core: one result per beat.
// ----------------------------------------------------------------------------
interface lssr_rsp_if;
	import lssr_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_out;
	logic              ok;
	logic              is_empty;
	logic [CNT_W-1:0]  entry_count;

	modport source (output valid, data_out, ok, is_empty, entry_count, input ready);
	modport sink   (input valid, data_out, ok, is_empty, entry_count, output ready);
endinterface

FILE: sv/lifo_stack_with_sort_reverse_core.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_sort_reverse_core
// Push writes and emits in one step; pop and peek read the store, then emit the result,
// stalling while the result register waits on the sink; the next item is accepted the cycle after a result issues.
// Reverse swaps entries from both ends inward and sort is an insertion sort;
// both walk the store with one access per step and a registered read.
// Reset clears the step counter, entry count and output valid; no store clearing pass.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_sort_reverse_core_assert.svh"

module lifo_stack_with_sort_reverse_core (
	input  logic          clk,
	input  logic          arst_n,
	lssr_req_if.sink      req,
	lssr_rsp_if.source    rsp
);
	import lssr_pkg::*;

	// Sequencer
	upc_t  pc_q, pc_d;
	cw_t   cw;
	logic  out_busy;
	logic  go;

	// Datapath registers
	cnt_t  cnt_q, cnt_d;
	cnt_t  lo_q, hi_q, i_q, j_q;
	data_t val_q, rd_q, t_q, v_q;
	logic  ok_q;
	cnt_t  cnt_m1, j_m1;

	// Store
	data_t stack_mem [DEPTH];
	logic  rd_en, wr_en;
	addr_t rd_addr, wr_addr;
	data_t wr_data;

	// Output register
	logic  out_valid_q;
	data_t out_data_q;
	logic  out_ok_q;
	cnt_t  out_cnt_q;
	data_t emit_data;
	logic  emit_ok;

	assign cw       = ucode(pc_q);
	assign out_busy = out_valid_q && !rsp.ready;
	assign go       = !(cw.emit && out_busy);
	assign req.ready = (pc_q == UPC_IDLE);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign j_m1     = j_q - CNT_W'(1);

	// Next step
	always_comb begin
		unique case (cw.cond)
			C_NEXT:     pc_d = pc_q + UPC_W'(1);
			C_ALWAYS:   pc_d = cw.tgt;
			C_DISPATCH: pc_d = req.valid ? entry_of(req.action) : pc_q;
			C_RV_END:   pc_d = (hi_q <= lo_q + CNT_W'(1)) ? cw.tgt : pc_q + UPC_W'(1);
			C_I_END:    pc_d = (i_q >= cnt_q) ? cw.tgt : pc_q + UPC_W'(1);
			C_J_ZERO:   pc_d = (j_q == '0) ? cw.tgt : pc_q + UPC_W'(1);
			C_NOT_LESS: pc_d = !(rd_q < v_q) ? cw.tgt : pc_q + UPC_W'(1);
			default:    pc_d = UPC_IDLE;
		endcase
		if (!go) begin
			pc_d = pc_q;
		end
	end

	// Store access and count update decoded from the control word
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = cnt_m1[ADDR_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = cnt_q[ADDR_W-1:0];
		wr_data   = val_q;
		cnt_d     = cnt_q;
		emit_data = '0;
		emit_ok   = 1'b0;
		unique case (cw.op)
			OP_PUSH: begin
				if (cnt_q < CNT_W'(DEPTH)) begin
					wr_en   = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
					emit_ok = 1'b1;
				end
			end
			OP_POP_RD: begin
				rd_en = 1'b1;
				if (cnt_q != '0) begin
					cnt_d = cnt_m1;
				end
			end
			OP_PEEK_RD: begin
				rd_en = 1'b1;
			end
			OP_EMIT_RD: begin
				emit_ok   = ok_q;
				emit_data = ok_q ? rd_q : '0;
			end
			OP_EMIT_OK: begin
				emit_ok = 1'b1;
			end
			OP_RV_TEST: begin
				rd_en   = 1'b1;
				rd_addr = lo_q[ADDR_W-1:0];
			end
			OP_RV_LOAD: begin
				rd_en   = 1'b1;
				rd_addr = hi_q[ADDR_W-1:0];
			end
			OP_WR_LO: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[ADDR_W-1:0];
				wr_data = rd_q;
			end
			OP_WR_HI: begin
				wr_en   = 1'b1;
				wr_addr = hi_q[ADDR_W-1:0];
				wr_data = t_q;
			end
			OP_SRT_OUTER: begin
				rd_en   = 1'b1;
				rd_addr = i_q[ADDR_W-1:0];
			end
			OP_SRT_RDPREV: begin
				rd_en   = 1'b1;
				rd_addr = j_m1[ADDR_W-1:0];
			end
			default: begin
			end
		endcase
		unique case (cw.wop)
			WOP_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = j_q[ADDR_W-1:0];
				wr_data = rd_q;
			end
			WOP_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = j_q[ADDR_W-1:0];
				wr_data = v_q;
			end
			default: begin
			end
		endcase
		if (!go) begin
			rd_en = 1'b0;
			wr_en = 1'b0;
			cnt_d = cnt_q;
		end
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= UPC_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q  <= pc_d;
			cnt_q <= cnt_d;
			if (cw.emit && go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and result beat
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			val_q <= req.push_value;
		end
		if (cw.emit && go) begin
			out_data_q <= emit_data;
			out_ok_q   <= emit_ok;
			out_cnt_q  <= cnt_d;
		end
		unique case (cw.op)
			OP_POP_RD, OP_PEEK_RD: ok_q <= (cnt_q != '0);
			OP_RV_INIT: begin
				lo_q <= '0;
				hi_q <= cnt_q;
			end
			OP_RV_TEST:    hi_q <= hi_q - CNT_W'(1);
			OP_RV_LOAD:    t_q  <= rd_q;
			OP_WR_HI:      lo_q <= lo_q + CNT_W'(1);
			OP_SRT_INIT:   i_q  <= CNT_W'(1);
			OP_SRT_OUTER:  j_q  <= i_q;
			OP_SRT_LOADV:  v_q  <= rd_q;
			default: begin
			end
		endcase
		unique case (cw.wop)
			WOP_SHIFT: j_q <= j_m1;
			WOP_PLACE: i_q <= i_q + CNT_W'(1);
			default: begin
			end
		endcase
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.data_out    = out_data_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.is_empty    = (out_cnt_q == '0);
	assign rsp.entry_count = out_cnt_q;

	// Checks
	`LSSR_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	`LSSR_ASSERT_NXT(a_emit_ends, clk, arst_n, cw.emit && go, pc_q == UPC_IDLE && out_valid_q)
	`LSSR_ASSERT_NXT(a_cnt_step, clk, arst_n, pc_q != UPC_PUSH && pc_q != UPC_POP, cnt_q == $past(cnt_q))

endmodule

FILE: sim/lifo_stack_with_sort_reverse_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_sort_reverse_core_test
// Self-checking bench for the stack core. A queue of requests feeds a bursty
// driver. Each accepted beat updates a shadow stack that predicts the
// response, and a stalling monitor checks every response field in order.
// Stimulus starts with a short directed pass over empty, single-entry and
// bad-code cases. Random episodes follow: fill, drain, mixed, sort-then-drain,
// reverse-then-drain and noise, with full-range, narrow and extreme values.
// ----------------------------------------------------------------------------
module lifo_stack_with_sort_reverse_core_test;
	import lssr_pkg::*;

	localparam int RANDOM_ITEMS = 1750;
	localparam int SETTLE_CYCLES = 40;
	localparam int REPORT_LIMIT = 40;
	localparam logic [ACT_W-1:0] ACT_CODE_MAX = '1;
	localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = ACT_W'(ACT_SORT + 1);

	// Value flavors for random pushes
	typedef enum int {
		VAL_FULL,
		VAL_NARROW,
		VAL_EXTREME
	} val_mode_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		data_t            value;
	} stack_req_t;

	typedef struct packed {
		data_t data;
		logic  ok;
		logic  empty;
		cnt_t  count;
	} stack_result_t;

	logic clk;
	logic arst_n;

	lssr_req_if req_ch ();
	lssr_rsp_if rsp_ch ();

	lifo_stack_with_sort_reverse_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stack_req_t    pending_requests[$];
	stack_result_t awaited_results[$];

	// Shadow copy of the stack contents
	data_t shadow_store[DEPTH];
	int    shadow_fill = 0;

	int mismatch_count = 0;
	int result_index = 0;
	int queued_random = 0;

	stack_req_t shown_req;
	int gap_left = 0;
	int burst_left = 1;
	int ready_mode = 0;
	int ready_left = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("lifo_stack_with_sort_reverse_core verification failed");
		$finish;
	end

	// Apply one action to the shadow stack and return the response it gives
	function automatic stack_result_t predict_stack_result(logic [ACT_W-1:0] code, data_t value);
		stack_result_t res;
		data_t tmp;
		int lo;
		int hi;
		int j;
		res.data = '0;
		res.ok = 1'b0;
		case (code)
			ACT_PUSH: begin
				if (shadow_fill < DEPTH) begin
					shadow_store[shadow_fill] = value;
					shadow_fill++;
					res.ok = 1'b1;
				end
			end
			ACT_POP: begin
				if (shadow_fill > 0) begin
					shadow_fill--;
					res.data = shadow_store[shadow_fill];
					res.ok = 1'b1;
				end
			end
			ACT_PEEK: begin
				if (shadow_fill > 0) begin
					res.data = shadow_store[shadow_fill - 1];
					res.ok = 1'b1;
				end
			end
			ACT_REV: begin
				lo = 0;
				hi = shadow_fill;
				while (hi > lo + 1) begin
					hi--;
					tmp = shadow_store[lo];
					shadow_store[lo] = shadow_store[hi];
					shadow_store[hi] = tmp;
					lo++;
				end
				res.ok = 1'b1;
			end
			ACT_SORT: begin
				// descending from the bottom, smallest ends on top
				for (int i = 1; i < shadow_fill; i++) begin
					tmp = shadow_store[i];
					j = i;
					while (j > 0 && shadow_store[j - 1] < tmp) begin
						shadow_store[j] = shadow_store[j - 1];
						j--;
					end
					shadow_store[j] = tmp;
				end
				res.ok = 1'b1;
			end
			default: ;
		endcase
		res.empty = (shadow_fill == 0);
		res.count = cnt_t'(shadow_fill);
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < REPORT_LIMIT)
			$display("%0t ns: response %0d %s: got %0d, want %0d",
				$time, result_index, what, got, want);
		mismatch_count++;
	endtask

	function automatic data_t pick_value(val_mode_t mode);
		data_t v;
		case (mode)
			VAL_NARROW: v = data_t'($urandom_range(0, 7));
			VAL_EXTREME: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = '1;
					2: v = {1'b1, {(DATA_W-1){1'b0}}};
					default: v = {1'b0, {(DATA_W-1){1'b1}}};
				endcase
			end
			default: v = data_t'($urandom);
		endcase
		return v;
	endfunction

	task automatic queue_item(logic [ACT_W-1:0] code, data_t value);
		stack_req_t r;
		r.action = code;
		r.value = value;
		pending_requests.push_back(r);
		queued_random++;
	endtask

	// Weighted pick among the actions; the last weight covers unused codes
	function automatic logic [ACT_W-1:0] pick_action(int w_push, int w_pop, int w_peek,
		int w_rev, int w_sort, int w_bad);
		int roll;
		roll = $urandom_range(0, w_push + w_pop + w_peek + w_rev + w_sort + w_bad - 1);
		if (roll < w_push) return ACT_PUSH;
		roll -= w_push;
		if (roll < w_pop) return ACT_POP;
		roll -= w_pop;
		if (roll < w_peek) return ACT_PEEK;
		roll -= w_peek;
		if (roll < w_rev) return ACT_REV;
		roll -= w_rev;
		if (roll < w_sort) return ACT_SORT;
		return ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_CODE_MAX));
	endfunction

	task automatic queue_weighted(int len, val_mode_t mode, int w_push, int w_pop, int w_peek,
		int w_rev, int w_sort, int w_bad);
		for (int i = 0; i < len; i++)
			queue_item(pick_action(w_push, w_pop, w_peek, w_rev, w_sort, w_bad),
				pick_value(mode));
	endtask

	// Push a run of values, reorder it, then pop it back out
	task automatic queue_reorder_drain(logic [ACT_W-1:0] reorder, int n, val_mode_t mode);
		for (int i = 0; i < n; i++)
			queue_item(ACT_PUSH, pick_value(mode));
		queue_item(ACT_PEEK, pick_value(VAL_FULL));
		queue_item(reorder, pick_value(VAL_FULL));
		queue_item(ACT_PEEK, pick_value(VAL_FULL));
		for (int i = 0; i < n + 2; i++)
			queue_item(ACT_POP, pick_value(VAL_FULL));
	endtask

	// Hold the stimulus until the block has answered everything
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || req_ch.valid || awaited_results.size() != 0);
	endtask

	// Stimulus, pauses and end of run
	initial begin
		val_mode_t mode;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_PUSH;
		req_ch.push_value = '0;
		rsp_ch.ready = 1'b0;

		// directed: empty stack, bad codes, single entry, extremes, duplicates
		queue_item(ACT_POP, '1);
		queue_item(ACT_PEEK, '0);
		queue_item(ACT_REV, '1);
		queue_item(ACT_SORT, '0);
		queue_item(ACT_UNUSED_FIRST, '1);
		queue_item(ACT_W'(ACT_UNUSED_FIRST + 1), '0);
		queue_item(ACT_CODE_MAX, '1);
		queue_item(ACT_PUSH, '0);
		queue_item(ACT_REV, '1);
		queue_item(ACT_SORT, '1);
		queue_item(ACT_PEEK, '0);
		queue_item(ACT_PUSH, '1);
		queue_item(ACT_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
		queue_item(ACT_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
		queue_item(ACT_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
		queue_item(ACT_REV, '0);
		queue_item(ACT_PEEK, '0);
		queue_item(ACT_SORT, '0);
		queue_item(ACT_PEEK, '0);
		for (int i = 0; i < 6; i++)
			queue_item(ACT_POP, pick_value(VAL_FULL));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		wait_idle();
		queued_random = 0;

		// fill past full, reorder a full stack, drain past empty
		for (int i = 0; i < DEPTH + 4; i++)
			queue_item(ACT_PUSH, pick_value(VAL_FULL));
		queue_item(ACT_SORT, pick_value(VAL_FULL));
		queue_item(ACT_PEEK, pick_value(VAL_FULL));
		queue_item(ACT_REV, pick_value(VAL_FULL));
		queue_item(ACT_PUSH, pick_value(VAL_FULL));
		for (int i = 0; i < DEPTH + 3; i++)
			queue_item(ACT_POP, pick_value(VAL_FULL));
		wait_idle();

		// random episodes
		while (queued_random < RANDOM_ITEMS) begin
			mode = val_mode_t'($urandom_range(VAL_FULL, VAL_EXTREME));
			case ($urandom_range(0, 5))
				0: queue_weighted($urandom_range(10, 40), mode, 80, 5, 5, 4, 3, 3);
				1: queue_weighted($urandom_range(10, 40), mode, 8, 70, 12, 4, 2, 4);
				2: queue_weighted($urandom_range(10, 40), mode, 35, 30, 12, 9, 6, 8);
				3: queue_reorder_drain(ACT_SORT, $urandom_range(1, 40), mode);
				4: queue_reorder_drain(ACT_REV, $urandom_range(1, 40), mode);
				default: queue_weighted($urandom_range(4, 12), mode, 20, 20, 15, 10, 5, 30);
			endcase
			if ($urandom_range(0, 7) == 0)
				wait_idle();
			else
				while (pending_requests.size() > 16)
					@(negedge clk);
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("lifo_stack_with_sort_reverse_core verification clean");
		end else begin
			$display("lifo_stack_with_sort_reverse_core verification failed");
		end
		$finish;
	end

	// Request driver: bursts of beats with random gaps, predict on accept
	always @(posedge clk) begin : drive_requests
		logic show;
		stack_req_t beat;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				awaited_results.push_back(predict_stack_result(shown_req.action, shown_req.value));
			if (!req_ch.valid || req_ch.ready) begin
				show = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_requests.size() > 0) begin
					beat = pending_requests.pop_front();
					shown_req = beat;
					show = 1'b1;
					req_ch.action <= beat.action;
					req_ch.push_value <= beat.value;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				req_ch.valid <= show;
			end
		end
	end

	// Response monitor: check each beat, stall on a pattern of shifting modes
	always @(posedge clk) begin : check_results
		stack_result_t want;
		logic ready_next;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("arrived with nothing awaited", 1, 0);
				end else begin
					want = awaited_results.pop_front();
					if (rsp_ch.data_out !== want.data)
						report_mismatch("data_out", rsp_ch.data_out, want.data);
					if (rsp_ch.ok !== want.ok)
						report_mismatch("ok", rsp_ch.ok, want.ok);
					if (rsp_ch.is_empty !== want.empty)
						report_mismatch("is_empty", rsp_ch.is_empty, want.empty);
					if (rsp_ch.entry_count !== want.count)
						report_mismatch("entry_count", rsp_ch.entry_count, want.count);
				end
				result_index++;
			end
			if (ready_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				ready_left = $urandom_range(4, 60);
			end else begin
				ready_left--;
			end
			case (ready_mode)
				0: ready_next = 1'b1;
				1: ready_next = ready_left[0];
				2: ready_next = ($urandom_range(0, 2) != 0);
				default: ready_next = (ready_left % 8 == 0);
			endcase
			rsp_ch.ready <= ready_next;
		end
	end

endmodule

FILE: sim.f
+incdir+sv
sv/lssr_pkg.sv
sv/lssr_req_if.sv
sv/lssr_rsp_if.sv
sv/lifo_stack_with_sort_reverse_core.sv
sim/lifo_stack_with_sort_reverse_core_test.sv
